// ===== src/e2g_pkg.sv =====
// Shared types, constants and helper functions for the ECEF to geodetic converter.
package e2g_pkg;

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE,
		S_C16_MUL,
		S_C16_DIV,
		S_PX_MUL,
		S_PY_MUL,
		S_P_SQRT,
		S_T_MUL_B,
		S_T_DIV_A,
		S_T_MUL_V,
		S_T_SQRT,
		S_T_DIV_S,
		S_T_MUL_C,
		S_T_DIV_P,
		S_NORM,
		S_LAT_CORDIC,
		S_ROT_CORDIC,
		S_T1_MUL,
		S_T2_MUL,
		S_A_MUL,
		S_B_MUL,
		S_AA_MUL,
		S_BB_MUL,
		S_R_SQRT,
		S_LON_CORDIC,
		S_POLAR,
		S_DONE
	} state_t;

	typedef enum logic {
		CORDIC_VECTOR,
		CORDIC_ROTATE
	} cordic_mode_t;

	// result status codes
	localparam logic [1:0] STATUS_CONVERGED  = 2'd0;
	localparam logic [1:0] STATUS_POLAR      = 2'd1;
	localparam logic [1:0] STATUS_ITER_LIMIT = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_SEMI_MAJOR = 2'd0;
	localparam logic [1:0] CFG_SEMI_MINOR = 2'd1;
	localparam logic [1:0] CFG_TOLERANCE  = 2'd2;

	localparam int CORDIC_STEPS = 32;
	localparam logic signed [63:0] INV_GAIN_Q30 = 64'sd652032874;
	localparam logic signed [33:0] QUARTER = 34'sd1073741824;

	// atan(2^-i) in 2^-31 semicircles
	function automatic logic [29:0] atan_entry(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'h20000000;
			5'd1:  r = 30'h12E4051E;
			5'd2:  r = 30'h09FB385B;
			5'd3:  r = 30'h051111D4;
			5'd4:  r = 30'h028B0D43;
			5'd5:  r = 30'h0145D7E1;
			5'd6:  r = 30'h00A2F61E;
			5'd7:  r = 30'h00517C55;
			5'd8:  r = 30'h0028BE53;
			5'd9:  r = 30'h00145F2F;
			5'd10: r = 30'h000A2F98;
			5'd11: r = 30'h000517CC;
			5'd12: r = 30'h00028BE6;
			5'd13: r = 30'h000145F3;
			5'd14: r = 30'h0000A2FA;
			5'd15: r = 30'h0000517D;
			5'd16: r = 30'h000028BE;
			5'd17: r = 30'h0000145F;
			5'd18: r = 30'h00000A30;
			5'd19: r = 30'h00000518;
			5'd20: r = 30'h0000028C;
			5'd21: r = 30'h00000146;
			5'd22: r = 30'h000000A3;
			5'd23: r = 30'h00000051;
			5'd24: r = 30'h00000029;
			5'd25: r = 30'h00000014;
			5'd26: r = 30'h0000000A;
			5'd27: r = 30'h00000005;
			5'd28: r = 30'h00000003;
			5'd29: r = 30'h00000001;
			5'd30: r = 30'h00000001;
			default: r = 30'h00000000;
		endcase
		return r;
	endfunction

	// (p >> 30) limited to 2^62
	function automatic logic [63:0] clip_q30(input logic [127:0] p);
		logic [63:0] r;
		if ((|p[127:93]) || (p[92:30] > 63'h4000_0000_0000_0000)) begin
			r = 64'h4000_0000_0000_0000;
		end else begin
			r = {1'b0, p[92:30]};
		end
		return r;
	endfunction

endpackage

// ===== src/e2g_mul.sv =====
// Shared 64x64 multiplier built from four 32x32 partial products.
module e2g_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  op_a,
	input  logic [63:0]  op_b,
	output logic         done,
	output logic [127:0] prod
);
	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q, done_q;
	logic [31:0]  a_part, b_part;
	logic [63:0]  pp;
	logic [1:0]   pos;
	logic [127:0] pp_ext;

	// partial product for the current pair of halves
	always_comb begin
		a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		pp = a_part * b_part;
		pos = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
		pp_ext = {64'd0, pp} << {pos, 5'd0};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			b_q <= op_b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_ext;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

// ===== src/e2g_div.sv =====
// Shared restoring divider, 128 by 64 bits, one quotient bit per cycle; saturates on overflow.
module e2g_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	output logic         done,
	output logic [63:0]  quo
);
	logic [63:0] rem_q, low_q, den_q, quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] rem2, diff;
	logic        ge, ovf;

	// one restoring step
	always_comb begin
		rem2 = {rem_q, low_q[63]};
		diff = rem2 - {1'b0, den_q};
		ge = rem2 >= {1'b0, den_q};
		ovf = (den == 64'd0) || (num[127:64] >= den);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				busy_q <= !ovf;
				done_q <= ovf;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[127:64];
			low_q <= num[63:0];
			den_q <= den;
			quo_q <= ovf ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : rem2[63:0];
			low_q <= {low_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule

// ===== src/e2g_sqrt.sv =====
// Shared integer square root of a 128-bit value, one root bit per cycle.
module e2g_sqrt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] rad,
	output logic         done,
	output logic [63:0]  root
);
	logic [127:0] rad_q;
	logic [65:0]  rem_q;
	logic [63:0]  root_q;
	logic [5:0]   cnt_q;
	logic         busy_q, done_q;
	logic [67:0]  cur, trial, diff;
	logic         ge;

	// one digit step: bring down two bits, try (root << 2) | 1
	always_comb begin
		cur = {rem_q, rad_q[127:126]};
		trial = {2'b00, root_q, 2'b01};
		diff = cur - trial;
		ge = cur >= trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= rad;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[125:0], 2'b00};
			rem_q <= ge ? diff[65:0] : cur[65:0];
			root_q <= {root_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ===== src/e2g_cordic.sv =====
// Shared CORDIC, vectoring or rotation mode, one of 32 micro-rotations per cycle.
module e2g_cordic (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  e2g_pkg::cordic_mode_t       mode,
	input  logic signed [63:0]          x0,
	input  logic signed [63:0]          y0,
	input  logic signed [33:0]          ang0,
	output logic                        done,
	output logic signed [63:0]          x,
	output logic signed [63:0]          y,
	output logic signed [33:0]          ang
);
	import e2g_pkg::*;

	cordic_mode_t       mode_q;
	logic signed [63:0] x_q, y_q, dx, dy;
	logic signed [33:0] ang_q, tab;
	logic [4:0]         i_q;
	logic               busy_q, done_q, sub;

	// micro-rotation direction and shifted terms
	always_comb begin
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		tab = $signed({4'd0, atan_entry(i_q)});
		sub = (mode_q == CORDIC_VECTOR) ? !y_q[63] : ang_q[33];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				i_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			mode_q <= mode;
			x_q <= x0;
			y_q <= y0;
			ang_q <= ang0;
		end else if (busy_q) begin
			if (sub) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				ang_q <= ang_q + tab;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				ang_q <= ang_q - tab;
			end
		end
	end

	assign done = done_q;
	assign x = x_q;
	assign y = y_q;
	assign ang = ang_q;
endmodule

// ===== src/ecef_to_geodetic_top.sv =====
// Top level: sequencer and working registers of the ECEF to geodetic converter.
//
// Channel   Direction  Handshake             Beat contents
// in        sink       in_valid / in_stall   x_mm, y_mm, z_mm
// out       source     out_valid / out_stall latitude, longitude, height_mm, status
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One point at a time. Off the polar axis a point takes N tan(latitude) updates
// (1 to MAX_ITERATIONS); each update is three divides, one square root and three
// multiplies on the shared units. A point on the polar axis skips the updates.
// Reset clears the sequencer and loads the WGS-84 axes and default tolerance.
// A finished result waits in the output register, so the next point is taken
// while out_stall holds the previous one.
module ecef_to_geodetic_top #(
	parameter int MAX_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [33:0] x_mm,
	input  logic signed [33:0] y_mm,
	input  logic signed [33:0] z_mm,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] latitude,
	output logic signed [31:0] longitude,
	output logic signed [33:0] height_mm,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [32:0]        cfg_data
);
	import e2g_pkg::*;

	localparam int IterW = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;

	state_t state_q, state_d;
	logic   launched_q;

	// configuration
	logic [32:0] semi_major_q, semi_minor_q;
	logic [15:0] tol_q;

	// working registers
	logic signed [33:0] x_q, y_q, z_q;
	logic [63:0]        c16_q, p16_q, v_q, s_q, um_q, xn_q, yn_q, ra_q, rb_q;
	logic [127:0]       acc_q;
	logic signed [63:0] t_q, n_q, cos_q, sin_q, t1_q, t2_q;
	logic signed [31:0] lat_q, lon_q;
	logic [33:0]        h_q;
	logic [1:0]         st_q;
	logic [IterW-1:0]   iter_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] lat_out_q, lon_out_q;
	logic [33:0]        h_out_q;
	logic [1:0]         st_out_q;

	// shared unit ports
	logic               mul_start, mul_done;
	logic [63:0]        mul_a, mul_b;
	logic [127:0]       mul_prod;
	logic               div_start, div_done;
	logic [127:0]       div_num;
	logic [63:0]        div_den, div_quo;
	logic               sqrt_start, sqrt_done;
	logic [127:0]       sqrt_rad;
	logic [63:0]        sqrt_root;
	logic               cor_start, cor_done;
	cordic_mode_t       cor_mode;
	logic signed [63:0] cor_x0, cor_y0, cor_x, cor_y;
	logic signed [33:0] cor_ang0, cor_ang;

	// derived values
	logic [32:0]        b_eff, a_minus_b;
	logic [33:0]        a_plus_b, abs_x, abs_y, abs_z;
	logic [63:0]        a64, b64, ut, abs_n, abs_cos, abs_sin, abs_z16, term, q_sat;
	logic [63:0]        abs_diff, root_a, root_b;
	logic               a_nz, launch, conv, last_iter, norm_left, norm_right;
	logic signed [63:0] z16, n_new, t_new, t_diff, xs, ys, lon_x, lon_y;
	logic signed [63:0] t1_new, t2_new;
	logic signed [33:0] lon_base, lat_mag;
	logic signed [31:0] lat_new;
	logic signed [65:0] hq, hr, hp;
	logic               load_out;

	function automatic logic [33:0] sat_h(input logic signed [65:0] v);
		logic [33:0] r;
		if (v > 66'sd8589934591) begin
			r = 34'h1_FFFF_FFFF;
		end else if (v < -66'sd8589934592) begin
			r = 34'h2_0000_0000;
		end else begin
			r = v[33:0];
		end
		return r;
	endfunction

	// shared units
	e2g_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
		.done(mul_done), .prod(mul_prod)
	);

	e2g_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	e2g_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .rad(sqrt_rad),
		.done(sqrt_done), .root(sqrt_root)
	);

	e2g_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .mode(cor_mode),
		.x0(cor_x0), .y0(cor_y0), .ang0(cor_ang0),
		.done(cor_done), .x(cor_x), .y(cor_y), .ang(cor_ang)
	);

	// operand preparation
	always_comb begin
		b_eff = (semi_minor_q > semi_major_q) ? semi_major_q : semi_minor_q;
		a_minus_b = semi_major_q - b_eff;
		a_plus_b = {1'b0, semi_major_q} + {1'b0, b_eff};
		a_nz = |semi_major_q;
		a64 = {31'd0, semi_major_q};
		b64 = {31'd0, b_eff};
		abs_x = x_q[33] ? 34'(-x_q) : 34'(x_q);
		abs_y = y_q[33] ? 34'(-y_q) : 34'(y_q);
		abs_z = z_q[33] ? 34'(-z_q) : 34'(z_q);
		z16 = {{14{z_q[33]}}, z_q, 16'd0};
		abs_z16 = {14'd0, abs_z, 16'd0};
		ut = t_q[63] ? 64'(-t_q) : 64'(t_q);
		abs_n = n_q[63] ? 64'(-n_q) : 64'(n_q);
		abs_cos = cos_q[63] ? 64'(-cos_q) : 64'(cos_q);
		abs_sin = sin_q[63] ? 64'(-sin_q) : 64'(sin_q);
	end

	// tan(latitude) update terms
	always_comb begin
		term = clip_q30(mul_prod);
		n_new = z16 + (t_q[63] ? -$signed(term) : $signed(term));
		q_sat = (div_quo > 64'h2000_0000_0000_0000) ? 64'h2000_0000_0000_0000 : div_quo;
		t_new = n_q[63] ? -$signed(q_sat) : $signed(q_sat);
		t_diff = t_new - t_q;
		abs_diff = t_diff[63] ? 64'(-t_diff) : 64'(t_diff);
		conv = abs_diff <= {48'd0, tol_q};
		last_iter = iter_q == IterW'(MAX_ITERATIONS - 1);
		norm_left = (xn_q < 64'h0200_0000_0000_0000) && (yn_q < 64'h0200_0000_0000_0000);
		norm_right = yn_q > 64'h0400_0000_0000_0000;
	end

	// latitude clamp, height terms and longitude quadrant fold
	always_comb begin
		if (cor_ang[33]) begin
			lat_mag = '0;
		end else if (cor_ang > QUARTER) begin
			lat_mag = QUARTER;
		end else begin
			lat_mag = cor_ang;
		end
		lat_new = t_q[63] ? -lat_mag[31:0] : lat_mag[31:0];
		t1_new = cos_q[63] ? -$signed(clip_q30(mul_prod)) : $signed(clip_q30(mul_prod));
		t2_new = (z_q[33] != sin_q[63]) ? -$signed(clip_q30(mul_prod))
			: $signed(clip_q30(mul_prod));
		root_a = mul_prod[77:14];
		root_b = mul_prod[77:14];
		hq = 66'(t1_q) + 66'(t2_q) - $signed({2'b00, sqrt_root});
		hr = (hq + 66'sd32768) >>> 16;
		hp = $signed({32'd0, abs_z}) - $signed({33'd0, b_eff});
		xs = {{6{x_q[33]}}, x_q, 24'd0};
		ys = {{6{y_q[33]}}, y_q, 24'd0};
		if (!x_q[33]) begin
			lon_x = xs;
			lon_y = ys;
			lon_base = '0;
		end else if (!y_q[33]) begin
			lon_x = ys;
			lon_y = -xs;
			lon_base = QUARTER;
		end else begin
			lon_x = -ys;
			lon_y = xs;
			lon_base = -QUARTER;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:       if (in_valid) state_d = S_C16_MUL;
			S_C16_MUL:    if (mul_done) state_d = S_C16_DIV;
			S_C16_DIV:    if (!a_nz || div_done) state_d = S_PX_MUL;
			S_PX_MUL:     if (mul_done) state_d = S_PY_MUL;
			S_PY_MUL:     if (mul_done) state_d = S_P_SQRT;
			S_P_SQRT: begin
				if (sqrt_done) state_d = (sqrt_root == 64'd0) ? S_POLAR : S_T_MUL_B;
			end
			S_T_MUL_B:    if (mul_done) state_d = S_T_DIV_A;
			S_T_DIV_A:    if (!a_nz || div_done) state_d = S_T_MUL_V;
			S_T_MUL_V:    if (mul_done) state_d = S_T_SQRT;
			S_T_SQRT:     if (sqrt_done) state_d = S_T_DIV_S;
			S_T_DIV_S:    if (div_done) state_d = S_T_MUL_C;
			S_T_MUL_C:    if (mul_done) state_d = S_T_DIV_P;
			S_T_DIV_P: begin
				if (div_done) state_d = (conv || last_iter) ? S_NORM : S_T_MUL_B;
			end
			S_NORM:       if (!norm_left && !norm_right) state_d = S_LAT_CORDIC;
			S_LAT_CORDIC: if (cor_done) state_d = S_ROT_CORDIC;
			S_ROT_CORDIC: if (cor_done) state_d = S_T1_MUL;
			S_T1_MUL:     if (mul_done) state_d = S_T2_MUL;
			S_T2_MUL:     if (mul_done) state_d = S_A_MUL;
			S_A_MUL:      if (mul_done) state_d = S_B_MUL;
			S_B_MUL:      if (mul_done) state_d = S_AA_MUL;
			S_AA_MUL:     if (mul_done) state_d = S_BB_MUL;
			S_BB_MUL:     if (mul_done) state_d = S_R_SQRT;
			S_R_SQRT:     if (sqrt_done) state_d = S_LON_CORDIC;
			S_LON_CORDIC: if (cor_done) state_d = S_DONE;
			S_POLAR:      state_d = S_DONE;
			S_DONE:       if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	// unit launches and operand selection
	always_comb begin
		launch = !launched_q;
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		sqrt_start = 1'b0;
		sqrt_rad = '0;
		cor_start = 1'b0;
		cor_mode = CORDIC_VECTOR;
		cor_x0 = '0;
		cor_y0 = '0;
		cor_ang0 = '0;
		case (state_q)
			S_C16_MUL: begin
				mul_start = launch;
				mul_a = 64'(a_minus_b);
				mul_b = 64'(a_plus_b);
			end
			S_C16_DIV: begin
				div_start = launch && a_nz;
				div_num = acc_q << 16;
				div_den = a64;
			end
			S_PX_MUL: begin
				mul_start = launch;
				mul_a = 64'(abs_x);
				mul_b = 64'(abs_x);
			end
			S_PY_MUL: begin
				mul_start = launch;
				mul_a = 64'(abs_y);
				mul_b = 64'(abs_y);
			end
			S_P_SQRT: begin
				sqrt_start = launch;
				sqrt_rad = acc_q << 32;
			end
			S_T_MUL_B: begin
				mul_start = launch;
				mul_a = b64;
				mul_b = ut;
			end
			S_T_DIV_A: begin
				div_start = launch && a_nz;
				div_num = acc_q;
				div_den = a64;
			end
			S_T_MUL_V: begin
				mul_start = launch;
				mul_a = v_q;
				mul_b = v_q;
			end
			S_T_SQRT: begin
				sqrt_start = launch;
				sqrt_rad = acc_q + (128'd1 << 60);
			end
			S_T_DIV_S: begin
				div_start = launch;
				div_num = {34'd0, ut, 30'd0};
				div_den = s_q;
			end
			S_T_MUL_C: begin
				mul_start = launch;
				mul_a = c16_q;
				mul_b = um_q;
			end
			S_T_DIV_P: begin
				div_start = launch;
				div_num = {34'd0, abs_n, 30'd0};
				div_den = p16_q;
			end
			S_LAT_CORDIC: begin
				cor_start = launch;
				cor_x0 = $signed(xn_q);
				cor_y0 = $signed(yn_q);
			end
			S_ROT_CORDIC: begin
				cor_start = launch;
				cor_mode = CORDIC_ROTATE;
				cor_x0 = INV_GAIN_Q30;
				cor_ang0 = 34'(lat_q);
			end
			S_T1_MUL: begin
				mul_start = launch;
				mul_a = p16_q;
				mul_b = abs_cos;
			end
			S_T2_MUL: begin
				mul_start = launch;
				mul_a = abs_z16;
				mul_b = abs_sin;
			end
			S_A_MUL: begin
				mul_start = launch;
				mul_a = a64;
				mul_b = abs_cos;
			end
			S_B_MUL: begin
				mul_start = launch;
				mul_a = b64;
				mul_b = abs_sin;
			end
			S_AA_MUL: begin
				mul_start = launch;
				mul_a = ra_q;
				mul_b = ra_q;
			end
			S_BB_MUL: begin
				mul_start = launch;
				mul_a = rb_q;
				mul_b = rb_q;
			end
			S_R_SQRT: begin
				sqrt_start = launch;
				sqrt_rad = acc_q;
			end
			S_LON_CORDIC: begin
				cor_start = launch;
				cor_x0 = lon_x;
				cor_y0 = lon_y;
			end
			default: begin
				launch = !launched_q;
			end
		endcase
	end

	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			launched_q <= 1'b0;
			out_valid_q <= 1'b0;
			semi_major_q <= 33'd6378137000;
			semi_minor_q <= 33'd6356752314;
			tol_q <= 16'd1074;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start || sqrt_start || cor_start) begin
				launched_q <= 1'b1;
			end else if (state_d != state_q) begin
				launched_q <= 1'b0;
			end
			out_valid_q <= load_out || (out_valid_q && out_stall);
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SEMI_MAJOR: semi_major_q <= cfg_data;
					CFG_SEMI_MINOR: semi_minor_q <= cfg_data;
					CFG_TOLERANCE:  tol_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					x_q <= x_mm;
					y_q <= y_mm;
					z_q <= z_mm;
				end
			end
			S_C16_MUL: if (mul_done) acc_q <= mul_prod;
			S_C16_DIV: begin
				if (!a_nz) c16_q <= '0;
				else if (div_done) c16_q <= div_quo;
			end
			S_PX_MUL: if (mul_done) acc_q <= mul_prod;
			S_PY_MUL: if (mul_done) acc_q <= acc_q + mul_prod;
			S_P_SQRT: begin
				if (sqrt_done) begin
					p16_q <= sqrt_root;
					t_q <= '0;
					iter_q <= '0;
				end
			end
			S_T_MUL_B: if (mul_done) acc_q <= mul_prod;
			S_T_DIV_A: begin
				if (!a_nz) v_q <= '0;
				else if (div_done) v_q <= div_quo;
			end
			S_T_MUL_V: if (mul_done) acc_q <= mul_prod;
			S_T_SQRT:  if (sqrt_done) s_q <= sqrt_root;
			S_T_DIV_S: if (div_done) um_q <= div_quo;
			S_T_MUL_C: if (mul_done) n_q <= n_new;
			S_T_DIV_P: begin
				if (div_done) begin
					t_q <= t_new;
					iter_q <= iter_q + IterW'(1);
					st_q <= conv ? STATUS_CONVERGED : STATUS_ITER_LIMIT;
					xn_q <= 64'd1 << 30;
					yn_q <= t_new[63] ? 64'(-t_new) : 64'(t_new);
				end
			end
			S_NORM: begin
				if (norm_left) begin
					xn_q <= xn_q << 1;
					yn_q <= yn_q << 1;
				end else if (norm_right) begin
					xn_q <= xn_q >> 1;
					yn_q <= yn_q >> 1;
				end
			end
			S_LAT_CORDIC: if (cor_done) lat_q <= lat_new;
			S_ROT_CORDIC: begin
				if (cor_done) begin
					cos_q <= cor_x;
					sin_q <= cor_y;
				end
			end
			S_T1_MUL: if (mul_done) t1_q <= t1_new;
			S_T2_MUL: if (mul_done) t2_q <= t2_new;
			S_A_MUL:  if (mul_done) ra_q <= root_a;
			S_B_MUL:  if (mul_done) rb_q <= root_b;
			S_AA_MUL: if (mul_done) acc_q <= mul_prod;
			S_BB_MUL: if (mul_done) acc_q <= acc_q + mul_prod;
			S_R_SQRT: if (sqrt_done) h_q <= sat_h(hr);
			S_LON_CORDIC: begin
				if (cor_done) lon_q <= 32'(lon_base + cor_ang);
			end
			S_POLAR: begin
				lat_q <= z_q[33] ? -32'sd1073741824 : 32'sd1073741824;
				lon_q <= '0;
				h_q <= sat_h(hp);
				st_q <= STATUS_POLAR;
			end
			default: ;
		endcase
		if (load_out) begin
			lat_out_q <= lat_q;
			lon_out_q <= lon_q;
			h_out_q <= h_q;
			st_out_q <= st_q;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign latitude = lat_out_q;
	assign longitude = lon_out_q;
	assign height_mm = $signed(h_out_q);
	assign status = st_out_q;

`ifndef SYNTHESIS
	// the shared units are never launched together
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({mul_start, div_start, sqrt_start, cor_start}))
		else $error("two shared units launched in one cycle");

	// no unit is launched twice in one sequencer step
	assert property (@(posedge clk) disable iff (!arst_n)
		launched_q |-> !(mul_start || div_start || sqrt_start || cor_start))
		else $error("unit relaunched before its result was taken");

	// an accepted point starts the sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_C16_MUL))
		else $error("accepted point did not start the sequencer");

	// a presented result has a defined status and latitude within a quarter turn
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status != 2'd3) && (latitude <= 32'sd1073741824)
			&& (latitude >= -32'sd1073741824)))
		else $error("result out of range");
`endif
endmodule
